@@ design/sstbs_pkg.sv @@
package sstbs_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int ENTRY_CHARS = 8;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  // Field widths of the channels and the length register
  localparam int IDX_W   = 8;
  localparam int WORD_W  = 64;
  localparam int KC_W    = 4;
  localparam int LEN_W   = 9;
  localparam int MATCH_W = 9;

  // Interval bounds run up to length + 1
  localparam int CNT_MIN_W = $clog2(TABLE_DEPTH + 2);
  localparam int CNT_W     = (CNT_MIN_W > LEN_W) ? CNT_MIN_W : LEN_W;

  // Queue between front and back end (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Action codes on the input channel
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef enum logic {
    OP_LOAD,
    OP_SEARCH
  } op_e;

  // One queued command: load carries text, search carries the masked key
  typedef struct packed {
    op_e                 op;
    logic [ADDR_W-1:0]   addr;
    logic [WORD_W-1:0]   word;
    logic [WORD_W-1:0]   mask;
  } queue_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Keep the leading kc characters, first character in the top byte
  function automatic logic [WORD_W-1:0] lead_mask(input logic [KC_W-1:0] kc);
    logic [KC_W-1:0] kc_c;
    kc_c      = (kc > KC_W'(ENTRY_CHARS)) ? KC_W'(ENTRY_CHARS) : kc;
    lead_mask = '0;
    for (int b = 0; b < WORD_W / 8; b++) begin
      lead_mask[WORD_W-1-8*b -: 8] = (KC_W'(b) < kc_c) ? 8'hFF : 8'h00;
    end
  endfunction

endpackage

@@ design/sstbs_req_if.sv @@
interface sstbs_req_if;
  import sstbs_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [IDX_W-1:0]    entry_index;
  logic [WORD_W-1:0]   entry_text;
  logic [WORD_W-1:0]   search_key;
  logic [KC_W-1:0]     key_chars;

  modport source (
    output valid, action, entry_index, entry_text, search_key, key_chars,
    input  ready
  );

  modport sink (
    input  valid, action, entry_index, entry_text, search_key, key_chars,
    output ready
  );
endinterface

@@ design/sstbs_rsp_if.sv @@
interface sstbs_rsp_if;
  import sstbs_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic [MATCH_W-1:0] match_index;

  modport source (
    output valid, found, match_index,
    input  ready
  );

  modport sink (
    input  valid, found, match_index,
    output ready
  );
endinterface

@@ design/sstbs_front.sv @@
module sstbs_front (
  sstbs_req_if.sink             req,
  input  sstbs_pkg::q_status_t  q_stat_i,
  output logic                  push_o,
  output sstbs_pkg::queue_item_t item_o
);
  import sstbs_pkg::*;

  logic load_in_range;

  // Take a transfer whenever the queue has room
  assign req.ready = !q_stat_i.full;

  // Loads beyond the table are dropped here and never reach the back end
  assign load_in_range = ({{(CNT_W-IDX_W){1'b0}}, req.entry_index} < CNT_W'(TABLE_DEPTH));

  assign push_o = req.valid && !q_stat_i.full
                  && ((req.action == ACT_SEARCH) || load_in_range);

  // Classify and pre-mask the key so the back end only compares
  always_comb begin
    item_o.addr = ADDR_W'(req.entry_index);
    if (req.action == ACT_SEARCH) begin
      item_o.op   = OP_SEARCH;
      item_o.mask = lead_mask(req.key_chars);
      item_o.word = req.search_key & item_o.mask;
    end else begin
      item_o.op   = OP_LOAD;
      item_o.mask = '0;
      item_o.word = req.entry_text;
    end
  end
endmodule

@@ design/sstbs_queue.sv @@
module sstbs_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  sstbs_pkg::queue_item_t item_i,
  input  logic                   pop_i,
  output sstbs_pkg::queue_item_t head_o,
  output sstbs_pkg::q_status_t   stat_o
);
  import sstbs_pkg::*;

  queue_item_t       slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign stat_o.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = slot_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (push_i && !pop_i)      count_q <= count_q + (QPTR_W+1)'(1);
      else if (pop_i && !push_i) count_q <= count_q - (QPTR_W+1)'(1);
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= item_i;
  end
endmodule

@@ design/sstbs_back.sv @@
module sstbs_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [sstbs_pkg::LEN_W-1:0] list_length_i,
  input  sstbs_pkg::queue_item_t    head_i,
  input  sstbs_pkg::q_status_t      q_stat_i,
  output logic                      pop_o,
  sstbs_rsp_if.source               rsp
);
  import sstbs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOW,
    ST_HIGH,
    ST_PROBE,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;

  logic [WORD_W-1:0] key_q, key_d, mask_q, mask_d;
  logic [CNT_W-1:0]  n_q, n_d, bot_q, bot_d, top_q, top_d, cur_q, cur_d, hit_q, hit_d;

  logic [WORD_W-1:0] mem_q [TABLE_DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic              rd_en, mem_we;
  logic [ADDR_W-1:0] rd_addr;

  logic [WORD_W-1:0] ent;
  logic              eq, gt, slot_free;
  logic [CNT_W-1:0]  n_clamp, bot_n, top_n, gap, mid_first, mid_n;
  logic [CNT_W:0]    sum_first, sum_n;

  // One-based position to table address
  function automatic logic [ADDR_W-1:0] addr_of(input logic [CNT_W-1:0] pos);
    logic [CNT_W-1:0] tmp;
    tmp     = pos - CNT_W'(1);
    addr_of = tmp[ADDR_W-1:0];
  endfunction

  // Compare against the entry read last cycle
  assign ent = rdata_q & mask_q;
  assign eq  = (key_q == ent);
  assign gt  = (key_q > ent);

  assign n_clamp = (CNT_W'(list_length_i) > CNT_W'(TABLE_DEPTH)) ?
                   CNT_W'(TABLE_DEPTH) : CNT_W'(list_length_i);

  // First probe of the interval (0, n + 1)
  assign sum_first = {1'b0, n_q} + (CNT_W+1)'(1);
  assign mid_first = sum_first[CNT_W:1];

  // Interval update after a probe that missed
  assign bot_n = gt ? cur_q : bot_q;
  assign top_n = gt ? top_q : cur_q;
  assign gap   = top_n - bot_n;
  assign sum_n = {1'b0, top_n} + {1'b0, bot_n};
  assign mid_n = sum_n[CNT_W:1];

  assign slot_free = !rsp.valid || rsp.ready;

  // Sequencer
  always_comb begin
    state_d = state_q;
    key_d   = key_q;
    mask_d  = mask_q;
    n_d     = n_q;
    bot_d   = bot_q;
    top_d   = top_q;
    cur_d   = cur_q;
    hit_d   = hit_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    mem_we  = 1'b0;
    pop_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          if (head_i.op == OP_LOAD) begin
            mem_we = 1'b1;
          end else begin
            key_d  = head_i.word;
            mask_d = head_i.mask;
            n_d    = n_clamp;
            hit_d  = '0;
            if (n_clamp == '0) begin
              state_d = ST_RESULT;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
              state_d = ST_LOW;
            end
          end
        end
      end
      // Key must not be below the first entry
      ST_LOW: begin
        if (gt || eq) begin
          rd_en   = 1'b1;
          rd_addr = addr_of(n_q);
          state_d = ST_HIGH;
        end else begin
          state_d = ST_RESULT;
        end
      end
      // Key must not be above the last entry in use
      ST_HIGH: begin
        if (!gt) begin
          bot_d   = '0;
          top_d   = n_q + CNT_W'(1);
          cur_d   = mid_first;
          rd_en   = 1'b1;
          rd_addr = addr_of(mid_first);
          state_d = ST_PROBE;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_PROBE: begin
        if (eq) begin
          hit_d   = cur_q;
          state_d = ST_RESULT;
        end else begin
          bot_d = bot_n;
          top_d = top_n;
          if (gap <= CNT_W'(1)) begin
            state_d = ST_RESULT;
          end else begin
            cur_d   = mid_n;
            rd_en   = 1'b1;
            rd_addr = addr_of(mid_n);
          end
        end
      end
      ST_RESULT: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      rsp.valid       <= 1'b0;
      rsp.found       <= 1'b0;
      rsp.match_index <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_RESULT && slot_free) begin
        rsp.valid       <= 1'b1;
        rsp.found       <= (hit_q != '0);
        rsp.match_index <= MATCH_W'(hit_q);
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Search datapath
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    mask_q <= mask_d;
    n_q    <= n_d;
    bot_q  <= bot_d;
    top_q  <= top_d;
    cur_q  <= cur_d;
    hit_q  <= hit_d;
  end

  // Entry table, one access per cycle, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[head_i.addr] <= head_i.word;
    if (rd_en)  rdata_q <= mem_q[rd_addr];
  end
endmodule

@@ design/sorted_string_table_binary_search.sv @@
// Sorted string table with binary search.
// req channel (valid/ready): action 0 loads entry_text at entry_index, action 1
// searches for the leading key_chars characters of search_key. rsp channel
// (valid/ready) returns found and the one-based match_index for each search;
// loads give no transfer on rsp. cfg_we_i/cfg_wdata_i set list_length; the user
// must write it only while no search is pending, as the block has no check for it.
// The front end classifies and masks each item into a two-entry queue, so req
// keeps moving while the back end searches or while a result waits on rsp.
// The back end writes a load from ST_IDLE. A search checks the first and last entry
// in ST_LOW and ST_HIGH, probes in ST_PROBE (at most 9 probes for 256 entries), and
// loads the output register in ST_RESULT; an empty list or a rejected key goes
// straight to ST_RESULT. Each probe is one read of the single-port table memory
// and one 64-bit compare, so the probe loop sets the rate.
// Reset clears list_length, the queue and the output register; table contents
// are undefined until loaded. While rsp is stalled, the finished result holds
// and the back end waits, and req stops once the queue fills.
module sorted_string_table_binary_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sstbs_req_if.sink                     req,
  sstbs_rsp_if.source                   rsp,
  input  logic                          cfg_we_i,
  input  logic [sstbs_pkg::LEN_W-1:0]   cfg_wdata_i
);
  import sstbs_pkg::*;

  logic [LEN_W-1:0] list_length_q;
  logic             q_push, q_pop;
  queue_item_t      q_in, q_head;
  q_status_t        q_stat;

  // Length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_length_q <= '0;
    end else if (cfg_we_i) begin
      list_length_q <= cfg_wdata_i;
    end
  end

  sstbs_front u_front (
    .req      (req),
    .q_stat_i (q_stat),
    .push_o   (q_push),
    .item_o   (q_in)
  );

  sstbs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_in),
    .pop_i  (q_pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  sstbs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .list_length_i (list_length_q),
    .head_i        (q_head),
    .q_stat_i      (q_stat),
    .pop_o         (q_pop),
    .rsp           (rsp)
  );

`ifndef NO_ASSERTIONS
  // A match always carries a nonzero index, a miss always index zero
  a_found_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> (rsp.found == (rsp.match_index != '0)))
    else $error("found flag disagrees with match_index");

  // An item pushed into an empty queue is visible to the back end next cycle
  a_queue_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && q_stat.empty) |=> !q_stat.empty)
    else $error("queue lost a pushed item");

  // The front end stalls only on a full queue
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req.ready |-> q_stat.full)
    else $error("input stalled with room in the queue");

  // The queue is never popped while empty
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");
`endif
endmodule
